>>> sv/assert_macros.svh
// Assertion macros used by the sorter's checker module.
// Standalone header; expects a clock and an active-low reset name as arguments.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> sv/dbs_pkg.sv
// Package for the descending bubble sorter: payload type and default capacity.
// No dependencies; compile first.
`default_nettype none

package dbs_pkg;

    localparam int SCORE_W = 32;
    localparam int DEFAULT_MAX_ITEMS = 16;

    typedef logic signed [SCORE_W-1:0] score_t;

endpackage

`default_nettype wire

>>> sv/dbs_if.sv
// Valid/ready channel interfaces for the sorter's input and result items.
// Depends on dbs_pkg.
`default_nettype none

interface dbs_in_if;
    logic            valid;
    logic            ready;
    dbs_pkg::score_t score;
    logic            last;

    modport source (output valid, output score, output last, input ready);
    modport sink   (input valid, input score, input last, output ready);
endinterface

interface dbs_out_if;
    logic            valid;
    logic            ready;
    dbs_pkg::score_t sorted_value;
    logic            last_res;
    logic            overflow;

    modport source (output valid, output sorted_value, output last_res, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_res, input overflow,
                    output ready);
endinterface

`default_nettype wire

>>> sv/descending_bubble_sorter_core.sv
// Descending bubble sorter: collects a set of signed values, sorts, emits largest first.
// Depends on dbs_pkg, dbs_if (dbs_in_if, dbs_out_if) and dbs_ram.
// Load: one value per cycle. Sort: each pass issues a read of entry 0, captures it,
//   compares once per entry and writes back, bound by the single compare unit and read port.
// Emit: each result is read from the RAM, then presented. Input is not ready from the
//   marked value until the final result is taken. Reset clears state, count, flag, index and limit.
`default_nettype none

module descending_bubble_sorter_core #(
    parameter int MAX_ITEMS = dbs_pkg::DEFAULT_MAX_ITEMS
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dbs_in_if.sink     values,
    dbs_out_if.source  sorted
);

    import dbs_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        S_LOAD = 7'b0000001,  // collect values of the set
        S_RD0  = 7'b0000010,  // issue read of entry 0 for a new pass
        S_LD0  = 7'b0000100,  // capture entry 0 as the carried value
        S_CMP  = 7'b0001000,  // compare carried value with the next entry
        S_WB   = 7'b0010000,  // write the carried value at the end of the pass
        S_ERD  = 7'b0100000,  // issue read of the next result
        S_EOUT = 7'b1000000   // present the result until taken
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic            ovf_reg, ovf_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [AW-1:0]   lim_reg, lim_next;
    score_t          carry_reg, carry_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    score_t          ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [SCORE_W-1:0] ram_rdata;
    score_t          rd_value;

    logic            in_acc;
    logic            out_acc;
    logic            full;
    logic            is_last_out;

    dbs_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_value = ram_rdata;

    assign values.ready = (state_reg == S_LOAD);
    assign in_acc       = values.valid && values.ready;
    assign out_acc      = sorted.valid && sorted.ready;
    assign full         = (fill_reg == CW'(MAX_ITEMS));
    assign is_last_out  = ((CW'(idx_reg) + CW'(1)) == fill_reg);

    // The RAM output register holds the result while the sink stalls.
    assign sorted.valid        = (state_reg == S_EOUT);
    assign sorted.sorted_value = rd_value;
    assign sorted.last_res     = is_last_out;
    assign sorted.overflow     = ovf_reg;

    // Each pass carries the smaller value rightward: one read, one compare and
    // one write per step. Swap only when the carried value is strictly smaller,
    // which keeps equal values in arrival order.
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;
        lim_next   = lim_reg;
        carry_next = carry_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = values.score;
        ram_re     = 1'b0;
        ram_raddr  = '0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (!full)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = fill_reg[AW-1:0];
                        fill_next = fill_reg + CW'(1);
                    end
                    else
                    begin
                        // Drop the value and flag the set.
                        ovf_next = 1'b1;
                    end
                    if (values.last)
                    begin
                        idx_next = '0;
                        if (fill_next == CW'(1))
                        begin
                            state_next = S_ERD;
                        end
                        else
                        begin
                            lim_next   = AW'(fill_next - CW'(1));
                            state_next = S_RD0;
                        end
                    end
                end
            end
            S_RD0:
            begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                state_next = S_LD0;
            end
            S_LD0:
            begin
                carry_next = rd_value;
                ram_re     = 1'b1;
                ram_raddr  = AW'(1);
                idx_next   = AW'(1);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg - AW'(1);
                if (carry_reg < rd_value)
                begin
                    ram_wdata = rd_value;
                end
                else
                begin
                    ram_wdata  = carry_reg;
                    carry_next = rd_value;
                end
                if (idx_reg == lim_reg)
                begin
                    state_next = S_WB;
                end
                else
                begin
                    // Fetch the next entry while this one is written back.
                    idx_next  = idx_reg + AW'(1);
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg + AW'(1);
                end
            end
            S_WB:
            begin
                ram_we    = 1'b1;
                ram_waddr = lim_reg;
                ram_wdata = carry_reg;
                if (lim_reg == AW'(1))
                begin
                    idx_next   = '0;
                    state_next = S_ERD;
                end
                else
                begin
                    lim_next   = lim_reg - AW'(1);
                    state_next = S_RD0;
                end
            end
            S_ERD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = idx_reg;
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                if (out_acc)
                begin
                    if (is_last_out)
                    begin
                        // Run complete: clear for the next set.
                        fill_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            fill_reg  <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
            lim_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
            lim_reg   <= lim_next;
        end
    end

    // Carried value is payload: no reset.
    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
    end

endmodule

`default_nettype wire

>>> sv/dbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                              clk,
    input  wire logic                              we,
    input  wire logic [$clog2(DEPTH)-1:0]          waddr,
    input  wire logic [WIDTH-1:0]                  wdata,
    input  wire logic                              re,
    input  wire logic [$clog2(DEPTH)-1:0]          raddr,
    output      logic [WIDTH-1:0]                  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/dbs_checker.sv
// Port-level checker for descending_bubble_sorter_core, bound into that module.
// Depends on dbs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dbs_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            in_valid,
    input wire logic            in_ready,
    input wire logic            in_last,
    input wire logic            out_valid,
    input wire logic            out_ready,
    input wire dbs_pkg::score_t out_value,
    input wire logic            out_last,
    input wire logic            out_overflow
);

    import dbs_pkg::*;

    logic in_acc;
    logic out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // A stalled result holds.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_last) && $stable(out_overflow))
    // Never take items while results are pending.
    `ASSERT_IMPLY(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    // A marked item closes the input side.
    `ASSERT_NEXT(a_last_closes, clk, rst_n, in_acc && in_last, !in_ready)
    // More results follow until the marked one is taken.
    `ASSERT_NEXT(a_run_continues, clk, rst_n, out_acc && !out_last, !in_ready)

endmodule

bind descending_bubble_sorter_core dbs_checker u_dbs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (values.valid),
    .in_ready     (values.ready),
    .in_last      (values.last),
    .out_valid    (sorted.valid),
    .out_ready    (sorted.ready),
    .out_value    (sorted.sorted_value),
    .out_last     (sorted.last_res),
    .out_overflow (sorted.overflow)
);

`default_nettype wire
